@@ rtl/core/m3au_pkg.sv @@
// ----------------------------------------------------------------------------
// m3au_pkg
// Shared types, codes and the product sequence table of the 3x3 fixed-point
// matrix arithmetic unit.
// ----------------------------------------------------------------------------
package m3au_pkg;

    // Fixed-point format and derived widths.
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 64;
    localparam int FPROD_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = FPROD_W + 2;
    localparam int NUM_W     = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int PC_W      = 6;

    // Operation codes.
    typedef logic [3:0] t_func;
    localparam t_func F_LOAD  = 4'd0;
    localparam t_func F_MUL   = 4'd1;
    localparam t_func F_ADD   = 4'd2;
    localparam t_func F_SUB   = 4'd3;
    localparam t_func F_SCALE = 4'd4;
    localparam t_func F_NEG   = 4'd5;
    localparam t_func F_TRANS = 4'd6;
    localparam t_func F_INV   = 4'd7;
    localparam t_func F_DET   = 4'd8;
    localparam t_func F_EQUAL = 4'd9;
    localparam t_func F_IDENT = 4'd10;

    // Status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_TRUE  = 2'd1;
    localparam t_status ST_FALSE = 2'd2;
    localparam t_status ST_SING  = 2'd3;

    // Operand sources of the shared multiplier.
    localparam logic [4:0] SRC_ACC   = 5'd0;
    localparam logic [4:0] SRC_B     = 5'd9;
    localparam logic [4:0] SRC_TMP   = 5'd18;
    localparam logic [4:0] SRC_SCALE = 5'd27;

    // Destination code of the determinant register.
    localparam logic [3:0] DST_DET = 4'd9;

    // Entry points of the product sequences.
    localparam logic [PC_W-1:0] MM_PC  = 6'd0;
    localparam logic [PC_W-1:0] SC_PC  = 6'd27;
    localparam logic [PC_W-1:0] DET_PC = 6'd36;

    // Index of the last division (element 8).
    localparam logic [3:0] LAST_IDX = 4'd8;

    // Terms of each adjugate element: t0*t1 - t2*t3.
    localparam logic [3:0] ADJ_T [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // One multiply-accumulate step.
    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic       sub;
        logic       last;
        logic [3:0] dst;
        logic       fin;
    } t_step;

    // Controller to datapath commands.
    typedef struct packed {
        logic            latch;
        logic            elem;
        logic            mul;
        logic            mac;
        logic            copy;
        logic            div_start;
        logic            set_sing;
        logic [PC_W-1:0] pc;
        logic [3:0]      div_idx;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic det_zero;
        logic div_done;
    } t_sts;

    // Saturate a wide signed sum to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
            res = v[31:0];
        end else if (v[SUM_W-1]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Product sequence table: matrix product, scale, adjugate and determinant.
    function automatic t_step step_rom(input logic [PC_W-1:0] pc);
        t_step s;
        s = '0;
        // Matrix product, three terms per element.
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    if (pc == PC_W'(int'(MM_PC) + r * 9 + c * 3 + k)) begin
                        s.src_a = 5'(int'(SRC_ACC) + r * 3 + k);
                        s.src_b = 5'(int'(SRC_B) + k * 3 + c);
                        s.last  = (k == 2);
                        s.dst   = 4'(r * 3 + c);
                        s.fin   = (r == 2) && (c == 2) && (k == 2);
                    end
                end
            end
        end
        // Scale by the scalar.
        for (int i = 0; i < 9; i++) begin
            if (pc == PC_W'(int'(SC_PC) + i)) begin
                s.src_a = 5'(int'(SRC_ACC) + i);
                s.src_b = SRC_SCALE;
                s.last  = 1'b1;
                s.dst   = 4'(i);
                s.fin   = (i == 8);
            end
        end
        // Adjugate, two terms per element.
        for (int k = 0; k < 9; k++) begin
            if (pc == PC_W'(int'(DET_PC) + 2 * k)) begin
                s.src_a = 5'(int'(SRC_ACC) + int'(ADJ_T[k][0]));
                s.src_b = 5'(int'(SRC_ACC) + int'(ADJ_T[k][1]));
            end
            if (pc == PC_W'(int'(DET_PC) + 2 * k + 1)) begin
                s.src_a = 5'(int'(SRC_ACC) + int'(ADJ_T[k][2]));
                s.src_b = 5'(int'(SRC_ACC) + int'(ADJ_T[k][3]));
                s.sub   = 1'b1;
                s.last  = 1'b1;
                s.dst   = 4'(k);
            end
        end
        // Determinant by expansion along row 0.
        for (int j = 0; j < 3; j++) begin
            if (pc == PC_W'(int'(DET_PC) + 18 + j)) begin
                s.src_a = 5'(int'(SRC_ACC) + j);
                s.src_b = 5'(int'(SRC_TMP) + 3 * j);
                s.last  = (j == 2);
                s.dst   = DST_DET;
                s.fin   = (j == 2);
            end
        end
        return s;
    endfunction

endpackage

@@ rtl/core/m3au_div.sv @@
// ----------------------------------------------------------------------------
// m3au_div
// Restoring divider, one quotient bit per cycle. Truncates toward zero and
// saturates the quotient to 32 bits.
// ----------------------------------------------------------------------------
module m3au_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [m3au_pkg::NUM_W-1:0]  i_num,
    input  logic signed [31:0]                 i_den,
    output logic                               o_done,
    output logic signed [31:0]                 o_quo
);

    logic                             r_busy;
    logic                             r_done;
    logic [m3au_pkg::CNT_W-1:0]       r_cnt;
    logic [31:0]                      r_rem;
    logic [m3au_pkg::NUM_W-1:0]       r_quo;
    logic [31:0]                      r_dmag;
    logic                             r_neg;

    logic [32:0]                      rem_sh;
    logic                             ge;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh = {r_rem, r_quo[m3au_pkg::NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dmag};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= m3au_pkg::CNT_W'(m3au_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == m3au_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitude datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_num[m3au_pkg::NUM_W-1] ? m3au_pkg::NUM_W'(-i_num) : i_num;
            r_rem  <= '0;
            r_dmag <= i_den[31] ? 32'(-i_den) : i_den;
            r_neg  <= i_num[m3au_pkg::NUM_W-1] ^ i_den[31];
        end else if (r_busy) begin
            r_quo <= {r_quo[m3au_pkg::NUM_W-2:0], ge};
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_dmag}) : rem_sh[31:0];
        end
    end

    // Sign and saturation of the quotient.
    always_comb begin
        if (r_neg) begin
            if (r_quo > m3au_pkg::NUM_W'(64'h8000_0000)) begin
                o_quo = 32'sh8000_0000;
            end else begin
                o_quo = 32'(-r_quo);
            end
        end else begin
            if (r_quo > m3au_pkg::NUM_W'(64'h7FFF_FFFF)) begin
                o_quo = 32'sh7FFF_FFFF;
            end else begin
                o_quo = r_quo[31:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/m3au_dp.sv @@
// ----------------------------------------------------------------------------
// m3au_dp
// Datapath: accumulator, operand latch, elementwise unit, shared multiplier
// with accumulation, scratch matrix and divider.
// ----------------------------------------------------------------------------
module m3au_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  m3au_pkg::t_cmd           i_cmd,
    output m3au_pkg::t_sts           o_sts,
    input  logic [3:0]               i_func,
    input  logic signed [31:0]       i_b [9],
    input  logic signed [31:0]       i_scale,
    input  logic                     i_cfg_wr_en,
    input  logic [30:0]              i_cfg_wr_data,
    output logic signed [31:0]       o_acc [9],
    output logic signed [31:0]       o_det,
    output logic [1:0]               o_status
);

    localparam logic signed [32:0] ONE33 = 33'sd1 <<< m3au_pkg::FRAC_BITS;

    logic signed [31:0]                  r_acc [9];
    logic signed [31:0]                  r_b [9];
    logic signed [31:0]                  r_tmp [9];
    logic signed [31:0]                  r_scale;
    logic signed [31:0]                  r_det;
    logic signed [m3au_pkg::PROD_W-1:0]  r_prod;
    logic signed [m3au_pkg::SUM_W-1:0]   r_sum;
    logic [3:0]                          r_func;
    logic [1:0]                          r_status;
    logic [30:0]                         r_tol;

    m3au_pkg::t_step                     step;
    logic signed [31:0]                  opnd [32];
    logic signed [m3au_pkg::FPROD_W-1:0] fprod;
    logic signed [m3au_pkg::SUM_W-1:0]   sum_new;
    logic signed [31:0]                  sat_val;
    logic signed [31:0]                  n_elem [9];
    logic signed [32:0]                  wide [9];
    logic signed [32:0]                  diff [9];
    logic [32:0]                         mag [9];
    logic                                test_ok;
    logic signed [m3au_pkg::NUM_W-1:0]   div_num;
    logic                                div_done;
    logic signed [31:0]                  div_quo;

    assign step = m3au_pkg::step_rom(i_cmd.pc);

    // Operand selection for the multiplier.
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            opnd[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            opnd[int'(m3au_pkg::SRC_ACC) + i] = r_acc[i];
            opnd[int'(m3au_pkg::SRC_B) + i]   = r_b[i];
            opnd[int'(m3au_pkg::SRC_TMP) + i] = r_tmp[i];
        end
        opnd[int'(m3au_pkg::SRC_SCALE)] = r_scale;
    end

    // Floored product and running sum.
    assign fprod   = r_prod[m3au_pkg::PROD_W-1:m3au_pkg::FRAC_BITS];
    assign sum_new = step.sub ? r_sum - m3au_pkg::SUM_W'(fprod)
                              : r_sum + m3au_pkg::SUM_W'(fprod);
    assign sat_val = m3au_pkg::sat32(sum_new);

    // Elementwise operations and the tolerance tests.
    always_comb begin
        test_ok = 1'b1;
        for (int i = 0; i < 9; i++) begin
            n_elem[i] = r_acc[i];
            wide[i]   = '0;
            diff[i]   = '0;
        end
        case (r_func)
            m3au_pkg::F_LOAD: begin
                for (int i = 0; i < 9; i++) n_elem[i] = r_b[i];
            end
            m3au_pkg::F_ADD: begin
                for (int i = 0; i < 9; i++) begin
                    wide[i]   = {r_acc[i][31], r_acc[i]} + {r_b[i][31], r_b[i]};
                    n_elem[i] = m3au_pkg::sat32(m3au_pkg::SUM_W'(wide[i]));
                end
            end
            m3au_pkg::F_SUB: begin
                for (int i = 0; i < 9; i++) begin
                    wide[i]   = {r_acc[i][31], r_acc[i]} - {r_b[i][31], r_b[i]};
                    n_elem[i] = m3au_pkg::sat32(m3au_pkg::SUM_W'(wide[i]));
                end
            end
            m3au_pkg::F_NEG: begin
                for (int i = 0; i < 9; i++) begin
                    wide[i]   = 33'sd0 - {r_acc[i][31], r_acc[i]};
                    n_elem[i] = m3au_pkg::sat32(m3au_pkg::SUM_W'(wide[i]));
                end
            end
            m3au_pkg::F_TRANS: begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) n_elem[r * 3 + c] = r_acc[c * 3 + r];
                end
            end
            m3au_pkg::F_EQUAL: begin
                for (int i = 0; i < 9; i++) begin
                    diff[i] = {r_b[i][31], r_b[i]} - {r_acc[i][31], r_acc[i]};
                end
            end
            m3au_pkg::F_IDENT: begin
                for (int i = 0; i < 9; i++) begin
                    diff[i] = {r_acc[i][31], r_acc[i]} -
                              ((i == 0 || i == 4 || i == 8) ? ONE33 : 33'sd0);
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 9; i++) begin
            mag[i] = diff[i][32] ? 33'(-diff[i]) : diff[i];
            if (mag[i] > {2'b00, r_tol}) test_ok = 1'b0;
        end
    end

    // Tolerance register and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= 31'd66;
            r_status <= m3au_pkg::ST_DONE;
        end else begin
            if (i_cfg_wr_en) r_tol <= i_cfg_wr_data;
            if (i_cmd.latch) begin
                r_status <= m3au_pkg::ST_DONE;
            end else if (i_cmd.elem &&
                         (r_func == m3au_pkg::F_EQUAL || r_func == m3au_pkg::F_IDENT)) begin
                r_status <= test_ok ? m3au_pkg::ST_TRUE : m3au_pkg::ST_FALSE;
            end else if (i_cmd.set_sing) begin
                r_status <= m3au_pkg::ST_SING;
            end
        end
    end

    // Accumulator matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) r_acc[i] <= '0;
        end else if (i_cmd.elem) begin
            for (int i = 0; i < 9; i++) r_acc[i] <= n_elem[i];
        end else if (i_cmd.copy) begin
            for (int i = 0; i < 9; i++) r_acc[i] <= r_tmp[i];
        end
    end

    // Operand latch, multiplier, running sum, scratch and determinant.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            for (int i = 0; i < 9; i++) r_b[i] <= i_b[i];
            r_scale <= i_scale;
            r_func  <= i_func;
            r_sum   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= opnd[step.src_a] * opnd[step.src_b];
        end
        if (i_cmd.mac) begin
            r_sum <= step.last ? '0 : sum_new;
            if (step.last) begin
                if (step.dst == m3au_pkg::DST_DET) begin
                    r_det <= sat_val;
                end else begin
                    r_tmp[step.dst] <= sat_val;
                end
            end
        end
        if (div_done) begin
            r_tmp[i_cmd.div_idx] <= div_quo;
        end
    end

    // Adjugate element scaled up by one fraction width over the determinant.
    assign div_num = {r_tmp[i_cmd.div_idx], m3au_pkg::FRAC_BITS'(0)};

    m3au_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_sts.det_zero = (r_det == 32'sd0);
    assign o_sts.div_done = div_done;
    assign o_acc          = r_acc;
    assign o_det          = r_det;
    assign o_status       = r_status;

endmodule

@@ rtl/core/m3au_ctrl.sv @@
// ----------------------------------------------------------------------------
// m3au_ctrl
// Controller: dispatches each operation and steps the product sequences and
// the divisions of the inverse.
// ----------------------------------------------------------------------------
module m3au_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [3:0]      i_func,
    input  m3au_pkg::t_sts  i_sts,
    output m3au_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_ELEM, S_MUL, S_ACC, S_COPY, S_CHK, S_DIV_GO, S_DIV_WAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        G_FIRST, G_ADJ, G_FINAL
    } t_stage;

    t_state                       r_state;
    t_stage                       r_stage;
    logic [m3au_pkg::PC_W-1:0]    r_pc;
    logic [3:0]                   r_idx;
    m3au_pkg::t_step              step;

    assign step = m3au_pkg::step_rom(r_pc);

    // State and sequence counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= G_FINAL;
            r_pc    <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (i_func)
                            m3au_pkg::F_MUL: begin
                                r_pc    <= m3au_pkg::MM_PC;
                                r_stage <= G_FIRST;
                                r_state <= S_MUL;
                            end
                            m3au_pkg::F_SCALE: begin
                                r_pc    <= m3au_pkg::SC_PC;
                                r_stage <= G_FIRST;
                                r_state <= S_MUL;
                            end
                            m3au_pkg::F_INV: begin
                                r_pc    <= m3au_pkg::DET_PC;
                                r_stage <= G_ADJ;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_state <= S_ELEM;
                            end
                        endcase
                    end
                end
                S_ELEM, S_COPY: begin
                    r_pc    <= m3au_pkg::DET_PC;
                    r_stage <= G_FINAL;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (step.fin) begin
                        unique case (r_stage)
                            G_FIRST: r_state <= S_COPY;
                            G_ADJ:   r_state <= S_CHK;
                            default: r_state <= S_OUT;
                        endcase
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    r_idx   <= '0;
                    r_state <= i_sts.det_zero ? S_OUT : S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        if (r_idx == m3au_pkg::LAST_IDX) begin
                            r_state <= S_COPY;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.latch     = start && (r_state == S_IDLE);
        o_cmd.elem      = (r_state == S_ELEM);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.mac       = (r_state == S_ACC);
        o_cmd.copy      = (r_state == S_COPY);
        o_cmd.div_start = (r_state == S_DIV_GO);
        o_cmd.set_sing  = (r_state == S_CHK) && i_sts.det_zero;
        o_cmd.pc        = r_pc;
        o_cmd.div_idx   = r_idx;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

@@ rtl/core/mat3_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// mat3_arith_unit_top
// 3x3 Q16.16 matrix arithmetic unit with one accumulator matrix.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays high
// until the result word has been shown. The result (accumulator, its
// determinant and status) is on the output ports for exactly one cycle,
// marked by o_done, and the receiver must take it then. Products go through
// the shared multiplier; the divider gives one quotient bit per cycle. Load,
// add, sub, neg, transpose, det, the tests and the unused codes use the
// elementwise unit; a matrix product and scale run their product sequence;
// an inverse runs the adjugate and determinant, then divides each element
// unless the matrix is singular. A new word can be taken at the edge that
// ends the cycle after the strobe. Every word but a singular inverse ends
// with the 21-product determinant of the new accumulator.
// ----------------------------------------------------------------------------
module mat3_arith_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_b_r0c0,
    input  logic signed [31:0] i_b_r0c1,
    input  logic signed [31:0] i_b_r0c2,
    input  logic signed [31:0] i_b_r1c0,
    input  logic signed [31:0] i_b_r1c1,
    input  logic signed [31:0] i_b_r1c2,
    input  logic signed [31:0] i_b_r2c0,
    input  logic signed [31:0] i_b_r2c1,
    input  logic signed [31:0] i_b_r2c2,
    input  logic signed [31:0] i_scale_factor,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    output logic               o_done,
    output logic signed [31:0] o_r_r0c0,
    output logic signed [31:0] o_r_r0c1,
    output logic signed [31:0] o_r_r0c2,
    output logic signed [31:0] o_r_r1c0,
    output logic signed [31:0] o_r_r1c1,
    output logic signed [31:0] o_r_r1c2,
    output logic signed [31:0] o_r_r2c0,
    output logic signed [31:0] o_r_r2c1,
    output logic signed [31:0] o_r_r2c2,
    output logic signed [31:0] o_det_value,
    output logic [1:0]         o_status
);

    m3au_pkg::t_cmd      cmd;
    m3au_pkg::t_sts      sts;
    logic signed [31:0]  b [9];
    logic signed [31:0]  acc [9];

    // Operand matrix, row-major.
    assign b[0] = i_b_r0c0;
    assign b[1] = i_b_r0c1;
    assign b[2] = i_b_r0c2;
    assign b[3] = i_b_r1c0;
    assign b[4] = i_b_r1c1;
    assign b[5] = i_b_r1c2;
    assign b[6] = i_b_r2c0;
    assign b[7] = i_b_r2c1;
    assign b[8] = i_b_r2c2;

    m3au_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    m3au_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_b           (b),
        .i_scale       (i_scale_factor),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_acc         (acc),
        .o_det         (o_det_value),
        .o_status      (o_status)
    );

    // Result matrix, row-major.
    assign o_r_r0c0 = acc[0];
    assign o_r_r0c1 = acc[1];
    assign o_r_r0c2 = acc[2];
    assign o_r_r1c0 = acc[3];
    assign o_r_r1c1 = acc[4];
    assign o_r_r1c2 = acc[5];
    assign o_r_r2c0 = acc[6];
    assign o_r_r2c1 = acc[7];
    assign o_r_r2c2 = acc[8];

    // A result word is only shown while the command is still in progress.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a command");

    // An accepted command makes the unit busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // One result word per command: the strobe is never high in consecutive cycles.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A skipped inverse reports a zero determinant.
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == m3au_pkg::ST_SING) |-> (o_det_value == 32'sd0))
        else $error("singular status with nonzero determinant");

endmodule
